[hdl/swrl_pkg.sv]
package swrl_pkg;

  // Widths of the fixed item fields.
  localparam int unsigned CountBits = 9;
  localparam int unsigned StampBits = 32;

  // Register reset values.
  localparam logic [CountBits-1:0] MaxActionsRst = 9'd128;
  localparam logic [StampBits-1:0] WindowRst     = 32'd3600;

  // Register indexes, taken from byte address bit 2.
  localparam logic RegMaxActions = 1'b0;
  localparam logic RegWindow     = 1'b1;

  // One input item.
  typedef struct packed {
    logic                 opcode;
    logic [StampBits-1:0] now_seconds;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                 accepted;
    logic                 limited;
    logic [CountBits-1:0] active_count;
    logic [CountBits-1:0] remaining;
    logic                 store_full;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StRead,
    StUpdate
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pop;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic expired;
  } dp_sts_t;

endpackage

[hdl/swrl_ctrl.sv]
module swrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  swrl_pkg::dp_sts_t sts_i,
  output swrl_pkg::dp_cmd_t cmd_o
);
  import swrl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and output-slot registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        // Drop the head stamp while it has expired, else go finish the item.
        if (!sts_i.empty && sts_i.expired) begin
          cmd_o.pop = 1'b1;
          state_d   = StRead;
        end else begin
          state_d = StUpdate;
        end
      end
      StRead: begin
        state_d = StCheck;
      end
      StUpdate: begin
        // Finish only once the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // The output slot fills on commit and empties when the result is taken.
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/swrl_datapath.sv]
module swrl_datapath #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  swrl_pkg::dp_cmd_t                      cmd_i,
  output swrl_pkg::dp_sts_t                      sts_o,
  input  swrl_pkg::in_item_t                     in_item_i,
  input  logic [swrl_pkg::CountBits-1:0]         action_limit_i,
  input  logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] window_i,
  output swrl_pkg::out_item_t                    out_item_o
);
  import swrl_pkg::*;

  // Stamps keep only the time bits that survive the input masking.
  localparam int unsigned NB   = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int unsigned IW   = $clog2(STORE_DEPTH);
  localparam int unsigned CW   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > CountBits) ? CW : CountBits;

  logic [NB-1:0] stamp_ring_q [STORE_DEPTH];
  logic [NB-1:0] rdata_q;
  logic          op_q;
  logic [NB-1:0] now_q;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  out_item_t     out_q;

  logic [CW:0]     tail_sum;
  logic [CW:0]     tail_sum_wrap;
  logic [IW-1:0]   tail_idx;
  logic [NB-1:0]   age;
  logic            full;
  logic            do_write;
  logic [CW-1:0]   new_count;
  logic [CMPW-1:0] cnt_x, max_x, rem_x;
  out_item_t       result;

  // Item registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_item_i.opcode;
      now_q <= in_item_i.now_seconds[NB-1:0];
    end
  end

  // Stamp memory: one write port at the tail, registered read at the head.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      stamp_ring_q[tail_idx] <= now_q;
    end
    rdata_q <= stamp_ring_q[head_q];
  end

  // Expiry test on the head stamp.
  assign age           = now_q - rdata_q;
  assign sts_o.expired = (rdata_q <= now_q) && (age >= window_i);
  assign sts_o.empty   = (count_q == '0);

  // Tail slot, wrapping modulo the store depth.
  assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
  always_comb begin
    if (tail_sum >= (CW+1)'(STORE_DEPTH)) begin
      tail_sum_wrap = tail_sum - (CW+1)'(STORE_DEPTH);
    end else begin
      tail_sum_wrap = tail_sum;
    end
  end
  assign tail_idx = tail_sum_wrap[IW-1:0];

  // Result of the item after pruning.
  assign full      = op_q && (count_q == CW'(STORE_DEPTH));
  assign do_write  = cmd_i.commit && op_q && !full;
  assign new_count = (op_q && !full) ? count_q + CW'(1) : count_q;
  assign cnt_x     = CMPW'(new_count);
  assign max_x     = CMPW'(action_limit_i);
  assign rem_x     = (max_x > cnt_x) ? max_x - cnt_x : '0;

  always_comb begin
    result.accepted     = op_q ? (!full && (cnt_x <= max_x)) : 1'b1;
    result.limited      = (cnt_x >= max_x);
    result.active_count = cnt_x[CountBits-1:0];
    result.remaining    = rem_x[CountBits-1:0];
    result.store_full   = full;
  end

  // Head and count updates.
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.pop) begin
      head_d  = (head_q == IW'(STORE_DEPTH - 1)) ? '0 : head_q + IW'(1);
      count_d = count_q - CW'(1);
    end else if (cmd_i.commit) begin
      count_d = new_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= result;
    end
  end

  assign out_item_o = out_q;

endmodule

[hdl/sliding_window_rate_limiter_top.sv]
// Sliding window rate limiter.
// Input channel (in_valid_i, in_ready_o, in_item_i) takes one item: an opcode
// (0 query, 1 record) and the current time in seconds, which must not go
// backwards. Output channel (out_valid_o, out_ready_i, out_item_o) returns one
// result item per input item, in order.
// Each item first drops expired stamps from the head of a ring of STORE_DEPTH
// entries; a record then appends the current time unless the ring is full.
// Steps: an accepted item is loaded, then the head stamp is checked; each
// dropped stamp adds a pop and a registered memory read before the next
// check, and a final update commits the result. One item is in work at a
// time; the dropping loop does one memory read and one compare per stamp.
// A finished result waits in an output register; a new item can be accepted
// meanwhile, but its result is held back until the receiver takes the old one.
// Registers on the APB port: the action limit at 0x0, window_seconds at 0x4.
// Reset empties the ring (no clearing pass: only the head and count reset),
// empties the output slot and loads an action limit of 128 and window 3600.
module sliding_window_rate_limiter_top #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swrl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swrl_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import swrl_pkg::*;

  localparam int unsigned NB = (TIME_BITS < 32) ? TIME_BITS : 32;

  logic [CountBits-1:0] action_limit_q;
  logic [NB-1:0]        window_q;
  logic                 cfg_wr;
  dp_cmd_t              cmd;
  dp_sts_t              sts;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_limit_q <= MaxActionsRst;
      window_q       <= WindowRst[NB-1:0];
    end else if (cfg_wr) begin
      if (paddr[2] == RegMaxActions) begin
        action_limit_q <= pwdata[CountBits-1:0];
      end else begin
        window_q <= pwdata[NB-1:0];
      end
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[2])
      RegMaxActions: prdata = 32'(action_limit_q);
      RegWindow:     prdata = 32'(window_q);
      default:       prdata = '0;
    endcase
  end

  swrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swrl_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_item_i      (in_item_i),
    .action_limit_i (action_limit_q),
    .window_i       (window_q),
    .out_item_o     (out_item_o)
  );

  // A stamp is dropped only while the ring holds entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.pop |-> !sts.empty)
    else $error("pop issued on an empty ring");

  // Only one item is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted while one is in work");

  // Every committed item shows up on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  // A dropped record is never reported as accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.store_full) |-> !out_item_o.accepted)
    else $error("full ring record reported accepted");

endmodule

[tb/tb_sliding_window_rate_limiter_top.sv]
module tb_sliding_window_rate_limiter_top;
  import swrl_pkg::*;

  localparam int unsigned LogDepth = 256;
  localparam logic OpQuery  = 1'b0;
  localparam logic OpRecord = 1'b1;
  localparam int unsigned MaxPrinted = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sliding_window_rate_limiter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow copy of the limiter: timestamp ring, head, fill level and limits.
  logic [StampBits-1:0] stamp_log [LogDepth];
  logic [7:0]           log_head = '0;
  logic [CountBits-1:0] log_count = '0;
  logic [CountBits-1:0] cfg_max = MaxActionsRst;
  logic [StampBits-1:0] cfg_window = WindowRst;

  in_item_t  request_q [$];
  out_item_t verdict_q [$];
  int unsigned queued_total = 0;
  int unsigned checked_total = 0;
  int unsigned error_count = 0;

  // Prune expired stamps from the head, then apply the item and form its verdict.
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    logic [7:0] slot;
    while (log_count != 0 && stamp_log[log_head] <= it.now_seconds &&
           (it.now_seconds - stamp_log[log_head]) >= cfg_window) begin
      log_head  = log_head + 8'd1;
      log_count = log_count - 9'd1;
    end
    r.accepted   = 1'b1;
    r.store_full = 1'b0;
    if (it.opcode == OpRecord) begin
      if (log_count == LogDepth) begin
        r.accepted   = 1'b0;
        r.store_full = 1'b1;
      end else begin
        slot = log_head + log_count[7:0];
        stamp_log[slot] = it.now_seconds;
        log_count = log_count + 9'd1;
        r.accepted = (log_count <= cfg_max);
      end
    end
    r.limited      = (log_count >= cfg_max);
    r.active_count = log_count;
    r.remaining    = (cfg_max > log_count) ? cfg_max - log_count : '0;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < MaxPrinted) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic        holding;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        verdict_q.push_back(apply_item(in_item));
        holding = 1'b0;
      end else begin
        holding = in_valid;
      end
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_valid <= 1'b1;
          in_item  <= request_q.pop_front();
          if (burst_left <= 1) begin
            if ($urandom_range(0, 9) == 0) begin
              burst_left = $urandom_range(40, 80);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest verdict and stalls in modes.
  out_item_t   want;
  out_item_t   seen;
  int unsigned stall_mode = 0;
  int unsigned stall_cyc = 0;
  int unsigned stall_div = 2;
  int unsigned ready_tick = 0;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      seen = out_item;
      if (verdict_q.size() == 0) begin
        flag_error("result item arrived with no verdict pending");
      end else begin
        want = verdict_q.pop_front();
        if (seen.accepted !== want.accepted)
          flag_error($sformatf("item %0d accepted got %b want %b",
                               checked_total, seen.accepted, want.accepted));
        if (seen.limited !== want.limited)
          flag_error($sformatf("item %0d limited got %b want %b",
                               checked_total, seen.limited, want.limited));
        if (seen.active_count !== want.active_count)
          flag_error($sformatf("item %0d active_count got %0d want %0d",
                               checked_total, seen.active_count, want.active_count));
        if (seen.remaining !== want.remaining)
          flag_error($sformatf("item %0d remaining got %0d want %0d",
                               checked_total, seen.remaining, want.remaining));
        if (seen.store_full !== want.store_full)
          flag_error($sformatf("item %0d store_full got %b want %b",
                               checked_total, seen.store_full, want.store_full));
        checked_total++;
      end
    end
    if (stall_cyc == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cyc  = $urandom_range(50, 300);
      stall_div  = $urandom_range(2, 8);
    end else begin
      stall_cyc--;
    end
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= $urandom_range(0, 1);
      end
      2: begin
        out_ready <= (ready_tick % stall_div) == 0;
      end
      default: begin
        out_ready <= ($urandom_range(0, 9) != 0);
      end
    endcase
    ready_tick++;
  end

  task automatic queue_item(input logic op, input logic [StampBits-1:0] stamp);
    in_item_t it;
    it.opcode      = op;
    it.now_seconds = stamp;
    request_q.push_back(it);
    queued_total++;
  endtask

  // Wait until every queued item has produced its checked result.
  task automatic drain();
    while (checked_total != queued_total) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; the register loads at the end of the access cycle.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegMaxActions) begin
      cfg_max = value[CountBits-1:0];
    end else begin
      cfg_window = value;
    end
  endtask

  task automatic set_limits(input logic [CountBits-1:0] mx, input logic [31:0] win);
    write_reg(RegMaxActions, {23'd0, mx});
    write_reg(RegWindow, win);
  endtask

  // Mostly nondecreasing times with random steps; a few items step back in time.
  task automatic load_random(input int n, input int unsigned span, input int rec_pct);
    logic [StampBits-1:0] t;
    logic                 op;
    logic [StampBits-1:0] stamp;
    t = $urandom();
    for (int k = 0; k < n; k++) begin
      op = ($urandom_range(1, 100) <= rec_pct) ? OpRecord : OpQuery;
      if ($urandom_range(0, 24) == 0) begin
        stamp = t - $urandom_range(0, span * 4);
      end else begin
        if ($urandom_range(0, 9) != 0) t = t + $urandom_range(0, span);
        stamp = t;
      end
      queue_item(op, stamp);
    end
    drain();
  endtask

  initial begin
    logic [CountBits-1:0] mx;
    logic [31:0]          win;
    int unsigned          eff;
    longint unsigned      wide;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits: expiry at the window edge, time stepping back, top of time range.
    queue_item(OpQuery, 32'd0);
    queue_item(OpRecord, 32'd0);
    queue_item(OpRecord, 32'd100);
    queue_item(OpQuery, 32'd3599);
    queue_item(OpQuery, 32'd3600);
    queue_item(OpRecord, 32'd50);
    queue_item(OpQuery, 32'd3700);
    queue_item(OpRecord, 32'hFFFF_FFFF);
    queue_item(OpQuery, 32'hFFFF_FFFF);
    drain();

    // Zero window and zero allowance: everything at or before now expires.
    set_limits(9'd0, 32'd0);
    queue_item(OpRecord, 32'd5);
    queue_item(OpQuery, 32'd5);
    queue_item(OpRecord, 32'd6);
    queue_item(OpRecord, 32'd6);
    drain();

    // One action per one-second window.
    set_limits(9'd1, 32'd1);
    queue_item(OpRecord, 32'd10);
    queue_item(OpRecord, 32'd10);
    queue_item(OpQuery, 32'd11);
    queue_item(OpRecord, 32'd11);
    drain();

    // Allowance above the ring depth and the widest window.
    set_limits(9'd511, 32'hFFFF_FFFF);
    queue_item(OpRecord, 32'd0);
    queue_item(OpRecord, 32'hFFFF_FFFF);
    queue_item(OpQuery, 32'hFFFF_FFFF);
    drain();

    // Random phases; one of them fills the ring and runs past full.
    for (int p = 0; p < 10; p++) begin
      if (p == 2) begin
        set_limits(9'd256, 32'hFFFF_FFFF);
        load_random(320, 2, 95);
      end else begin
        case ($urandom_range(0, 5))
          0: mx = 9'd0;
          1: mx = 9'd1;
          2: mx = 9'd256;
          3: mx = 9'd511;
          4: mx = $urandom_range(2, 40);
          default: mx = $urandom_range(41, 255);
        endcase
        case ($urandom_range(0, 4))
          0: win = 32'd0;
          1: win = 32'd1;
          2: win = 32'hFFFF_FFFF;
          3: win = $urandom_range(2, 500);
          default: win = $urandom_range(501, 100000);
        endcase
        eff  = (mx > 9'd256) ? 256 : mx;
        wide = (64'(win) * 2) / (eff + 1);
        if (wide == 0) wide = 1;
        if (wide > 1_000_000) wide = 1_000_000;
        set_limits(mx, win);
        load_random(110, int'(wide), 85);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      flag_error($sformatf("%0d verdicts never matched by a result", verdict_q.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
hdl/swrl_pkg.sv
hdl/swrl_ctrl.sv
hdl/swrl_datapath.sv
hdl/sliding_window_rate_limiter_top.sv
tb/tb_sliding_window_rate_limiter_top.sv
